// File: rtl/core/sbl_pkg.sv
// ----------------------------------------------------------------------------
// sbl_pkg
// Shared types and constants for the spectrum bar level block.
// ----------------------------------------------------------------------------
`default_nettype none

package sbl_pkg;

	// Frame geometry.
	localparam int BINS  = 128;
	localparam int GROUP = 8;
	localparam int BIN_W = 7;
	localparam int GRP_W = 3;

	// Datapath widths.
	localparam int MAG_W  = 16;
	localparam int SUM_W  = 19;             // GROUP magnitudes of MAG_W bits
	localparam int Q_W    = 24;             // floor(sum * 250 / GROUP)
	localparam int ROOT_W = Q_W / 2;
	localparam int ROOT_STEPS = Q_W / 2;    // two radicand bits per step
	localparam int ITER_W = 4;
	localparam int LVL_W  = 11;
	localparam int ROWS_W = 8;

	localparam logic [GRP_W-1:0]  GRP_LAST  = GRP_W'(GROUP - 1);
	localparam logic [BIN_W-1:0]  BIN_LAST  = BIN_W'(BINS - 1);
	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ROOT_STEPS - 1);
	localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(60);

	typedef struct packed {
		logic [MAG_W-1:0] magnitude;
		logic             first_of_frame;
	} sample_t;

	typedef struct packed {
		logic [BIN_W-1:0]  bin_index;
		logic [LVL_W-1:0]  bar_level;
		logic [ROWS_W-1:0] bar_height;
		logic              last_of_frame;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCALE,
		ST_ROOT,
		ST_UPDATE
	} state_t;

endpackage

`default_nettype wire

// File: rtl/core/spectrum_bar_levels_with_decay.sv
// ----------------------------------------------------------------------------
// spectrum_bar_levels_with_decay
// Groups FFT magnitudes into bins and turns each bin into a falling bar level.
// ----------------------------------------------------------------------------
// Usage notes.
// The sample channel (sample_valid, sample_ready, sample) carries one Q8.8
// magnitude per transaction together with a frame-start flag. Every GROUP
// samples form one bin; the transaction that completes a group launches the
// bar computation, and one result transaction (result_valid, result_ready,
// result) follows for that bin. Samples that do not complete a group are
// taken one per cycle while the block idles.
// The bin height is half the integer square root of the scaled group sum,
// rounded with halves going up. The root comes from a bit-serial unit that
// retires two radicand bits per cycle, so a completing sample keeps
// sample_ready low through the scaling state, the root steps and the level
// update state. The result is valid in the cycle after the update.
// The result sits in an output register. While it waits for result_ready the
// block keeps taking samples; only the next level update stalls until the
// register is free, and sample_ready stays low meanwhile.
// display_rows is to be written through rows_we / rows_wdata while the block
// idles; the block does not enforce this. Reset clears the counters, the
// group sum and bin valid flags, not the level store; display_rows resets to 60.
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_bar_levels_with_decay (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          sample_valid,
	output logic                               sample_ready,
	input  wire sbl_pkg::sample_t              sample,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output sbl_pkg::result_t                   result,
	input  wire logic                          rows_we,
	input  wire logic [sbl_pkg::ROWS_W-1:0]    rows_wdata
);

	// Control state.
	sbl_pkg::state_t state_q, state_d;
	logic [sbl_pkg::ROWS_W-1:0] rows_q;
	logic [sbl_pkg::SUM_W-1:0]  sum_q;
	logic [sbl_pkg::GRP_W-1:0]  cnt_q;
	logic [sbl_pkg::BIN_W-1:0]  cur_bin_q;
	logic [sbl_pkg::BIN_W-1:0]  bin_q;
	logic [sbl_pkg::ITER_W-1:0] iter_q;
	logic [sbl_pkg::BINS-1:0]   vld_q;
	logic                       result_valid_q;

	// Datapath registers.
	logic [sbl_pkg::Q_W-1:0]    rad_q;
	logic [sbl_pkg::ROOT_W+1:0] rem_q;
	logic [sbl_pkg::ROOT_W-1:0] root_q;
	logic [sbl_pkg::LVL_W-1:0]  rd_q;
	logic                       old_vld_q;
	sbl_pkg::result_t           result_q;

	// Level store, one entry per bin.
	logic [sbl_pkg::LVL_W-1:0]  lvl_mem [sbl_pkg::BINS];

	logic                       accept;
	logic                       grp_done;
	logic                       out_load;
	logic [sbl_pkg::GRP_W-1:0]  cnt_base;
	logic [sbl_pkg::SUM_W-1:0]  sum_base;
	logic [sbl_pkg::SUM_W-1:0]  sum_next;
	logic [sbl_pkg::BIN_W-1:0]  bin_base;
	logic [sbl_pkg::Q_W+1:0]    scaled;
	logic [sbl_pkg::ROOT_W+3:0] rem_trial;
	logic [sbl_pkg::ROOT_W+3:0] root_trial;
	logic [sbl_pkg::ROOT_W+3:0] rem_diff;
	logic [sbl_pkg::ROOT_W:0]   root_inc;
	logic [sbl_pkg::LVL_W-1:0]  height;
	logic [sbl_pkg::LVL_W-1:0]  lvl_old;
	logic [sbl_pkg::LVL_W-1:0]  lvl_new;
	logic [sbl_pkg::ROWS_W-1:0] bar;

	// ------------------------------------------------------------------
	// Sample side: a frame start clears the counters before this sample
	// is counted, so the base values are chosen first.
	// ------------------------------------------------------------------
	assign accept   = sample_valid && sample_ready;
	assign cnt_base = sample.first_of_frame ? '0 : cnt_q;
	assign sum_base = sample.first_of_frame ? '0 : sum_q;
	assign bin_base = sample.first_of_frame ? '0 : cur_bin_q;
	assign sum_next = sum_base + sbl_pkg::SUM_W'(sample.magnitude);
	assign grp_done = (cnt_base == sbl_pkg::GRP_LAST);

	// ------------------------------------------------------------------
	// Scaling: q = floor(sum * 125 / 4), with sum * 125 formed as
	// sum * 128 - sum * 3. The sum waits in the low bits of rad_q.
	// ------------------------------------------------------------------
	always_comb begin
		scaled = {rad_q[sbl_pkg::SUM_W-1:0], 7'b0}
			- ({1'b0, rad_q[sbl_pkg::SUM_W-1:0], 1'b0}
			+ (sbl_pkg::Q_W+2)'(rad_q[sbl_pkg::SUM_W-1:0]));
	end

	// ------------------------------------------------------------------
	// One restoring square root step: bring down the next two radicand
	// bits and try to subtract 4 * root + 1.
	// ------------------------------------------------------------------
	assign rem_trial  = {rem_q, rad_q[sbl_pkg::Q_W-1 -: 2]};
	assign root_trial = {2'b0, root_q, 2'b01};
	assign rem_diff   = rem_trial - root_trial;

	// ------------------------------------------------------------------
	// Level update: the height halves the root, rounding halves up. A bar
	// rises at once to a height that is not lower and otherwise falls by
	// one. A bin never written reads as level zero.
	// ------------------------------------------------------------------
	assign root_inc = {1'b0, root_q} + (sbl_pkg::ROOT_W+1)'(1);
	assign height   = root_inc[sbl_pkg::LVL_W:1];
	assign lvl_old  = old_vld_q ? rd_q : '0;
	assign lvl_new  = (height < lvl_old) ? lvl_old - sbl_pkg::LVL_W'(1) : height;
	assign bar      = (lvl_new > sbl_pkg::LVL_W'(rows_q))
		? rows_q : lvl_new[sbl_pkg::ROWS_W-1:0];

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			sbl_pkg::ST_IDLE: begin
				if (accept && grp_done) begin
					state_d = sbl_pkg::ST_SCALE;
				end
			end
			sbl_pkg::ST_SCALE: begin
				state_d = sbl_pkg::ST_ROOT;
			end
			sbl_pkg::ST_ROOT: begin
				if (iter_q == sbl_pkg::ITER_LAST) begin
					state_d = sbl_pkg::ST_UPDATE;
				end
			end
			sbl_pkg::ST_UPDATE: begin
				if (out_load) begin
					state_d = sbl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sbl_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		sample_ready = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			sbl_pkg::ST_IDLE: begin
				sample_ready = 1'b1;
			end
			sbl_pkg::ST_UPDATE: begin
				out_load = !result_valid_q || result_ready;
			end
			default: begin
				sample_ready = 1'b0;
				out_load     = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= sbl_pkg::ST_IDLE;
			rows_q         <= sbl_pkg::ROWS_RESET;
			sum_q          <= '0;
			cnt_q          <= '0;
			cur_bin_q      <= '0;
			bin_q          <= '0;
			iter_q         <= '0;
			vld_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rows_we) begin
				rows_q <= rows_wdata;
			end
			if (accept) begin
				if (grp_done) begin
					sum_q     <= '0;
					cnt_q     <= '0;
					bin_q     <= bin_base;
					cur_bin_q <= (bin_base == sbl_pkg::BIN_LAST)
						? '0 : bin_base + sbl_pkg::BIN_W'(1);
				end else begin
					sum_q     <= sum_next;
					cnt_q     <= cnt_base + sbl_pkg::GRP_W'(1);
					cur_bin_q <= bin_base;
				end
			end
			if (state_q == sbl_pkg::ST_SCALE) begin
				iter_q <= '0;
			end else if (state_q == sbl_pkg::ST_ROOT) begin
				iter_q <= iter_q + sbl_pkg::ITER_W'(1);
			end
			if (out_load) begin
				vld_q[bin_q] <= 1'b1;
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Square root datapath and output payload.
	always_ff @(posedge clk) begin
		if (accept && grp_done) begin
			rad_q <= sbl_pkg::Q_W'(sum_next);
		end else if (state_q == sbl_pkg::ST_SCALE) begin
			rad_q  <= scaled[sbl_pkg::Q_W+1:2];
			rem_q  <= '0;
			root_q <= '0;
		end else if (state_q == sbl_pkg::ST_ROOT) begin
			rad_q <= {rad_q[sbl_pkg::Q_W-3:0], 2'b0};
			if (!rem_diff[sbl_pkg::ROOT_W+3]) begin
				rem_q  <= rem_diff[sbl_pkg::ROOT_W+1:0];
				root_q <= {root_q[sbl_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_trial[sbl_pkg::ROOT_W+1:0];
				root_q <= {root_q[sbl_pkg::ROOT_W-2:0], 1'b0};
			end
		end
		if (out_load) begin
			result_q.bin_index     <= bin_q;
			result_q.bar_level     <= lvl_new;
			result_q.bar_height    <= bar;
			result_q.last_of_frame <= (bin_q == sbl_pkg::BIN_LAST);
		end
	end

	// Level store: read data is registered, the write lands with the result.
	always_ff @(posedge clk) begin
		if (out_load) begin
			lvl_mem[bin_q] <= lvl_new;
		end
		rd_q      <= lvl_mem[bin_q];
		old_vld_q <= vld_q[bin_q];
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// File: rtl/core/sbl_checker.sv
// ----------------------------------------------------------------------------
// sbl_checker
// Port-level checks for the spectrum bar level block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       sample_ready,
	input wire logic                       result_valid,
	input wire logic                       result_ready,
	input wire sbl_pkg::result_t           result
);

	// A pending result holds until it is taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed or dropped while stalled");

	// The displayed height never exceeds the stored level.
	a_height_le_level: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.bar_height <= result.bar_level))
		else $error("bar height above bar level");

	// The frame end marks exactly the last bin.
	a_last_bin: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.last_of_frame == (result.bin_index == sbl_pkg::BIN_LAST)))
		else $error("last_of_frame does not match bin index");

	// A new result follows a cycle in which samples were held off.
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(sample_ready))
		else $error("result appeared without a level update");

endmodule

bind spectrum_bar_levels_with_decay sbl_checker u_sbl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_ready (sample_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

`default_nettype wire
